/* hw/rtl/euler_angles_to_basis_vectors_core_macros.svh */
// assertion helpers used by the checker file
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_CORE_MACROS_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_CORE_MACROS_SVH

// same-cycle implication, masked while in reset
`define EABV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define EABV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/eabv_pkg.sv */
`default_nettype none

package eabv_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam int CORDIC_STEPS = 30;
  localparam int INNER_BITS   = 30;           // Q2.30 working format
  localparam int CW   = 34;                   // cordic x/y width
  localparam int ZW   = 33;                   // cordic angle accumulator width
  localparam int SCW  = 32;                   // sine / cosine width
  localparam int PW   = 2 * SCW;              // full product width
  localparam int RW   = 34;                   // rounded product width
  localparam int SW   = 36;                   // sum width
  localparam int OUT_W   = 16;
  localparam int NUM_OUT = 9;
  localparam int OUT_TDATA_W = NUM_OUT * OUT_W;

  // input register + one stage per micro-rotation + quadrant, 2x(mul, round), sum, out
  localparam int PIPE_DEPTH = CORDIC_STEPS + 8;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(536870912);
      1:  v = ZW'(316933406);
      2:  v = ZW'(167458907);
      3:  v = ZW'(85004756);
      4:  v = ZW'(42667331);
      5:  v = ZW'(21354465);
      6:  v = ZW'(10679838);
      7:  v = ZW'(5340245);
      8:  v = ZW'(2670163);
      9:  v = ZW'(1335087);
      10: v = ZW'(667544);
      11: v = ZW'(333772);
      12: v = ZW'(166886);
      13: v = ZW'(83443);
      14: v = ZW'(41722);
      15: v = ZW'(20861);
      16: v = ZW'(10430);
      17: v = ZW'(5215);
      18: v = ZW'(2608);
      19: v = ZW'(1304);
      20: v = ZW'(652);
      21: v = ZW'(326);
      22: v = ZW'(163);
      23: v = ZW'(81);
      24: v = ZW'(41);
      25: v = ZW'(20);
      26: v = ZW'(10);
      27: v = ZW'(5);
      28: v = ZW'(3);
      29: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.30 x Q2.30 product back to Q2.30, rounded half up
  function automatic logic signed [RW-1:0] qround(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + (PW'(1) <<< (INNER_BITS - 1));
    return t[INNER_BITS +: RW];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/euler_angles_to_basis_vectors_core.sv */
`default_nettype none
// channel | dir | tdata fields, lowest bit first                 | tuser / tlast
// in_     | in  | pitch_angle, yaw_angle, roll_angle (ANGLE_BITS) | none
// out_    | out | forward_x/y/z, right_x/y/z, up_x/y/z (16 each)  | none
//
// one item per cycle while out_tready holds; on its way to out_tvalid an item passes
// the 30-stage cordic (one micro-rotation per stage) and then the product stages
// rst_n is synchronous and clears only the valid bits, payload registers are not reset
// a stall on the output freezes the whole pipe; the input register still takes an item
// whenever it is empty, so an item is accepted while a finished result waits

module euler_angles_to_basis_vectors_core #(
  parameter int ANGLE_BITS    = eabv_pkg::ANGLE_BITS_DEF,
  parameter int FRACTION_BITS = eabv_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // pitch_angle, yaw_angle, roll_angle, zero padded to bytes
  input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // forward_x, forward_y, forward_z, right_x, right_y, right_z, up_x, up_y, up_z
  output logic [eabv_pkg::OUT_TDATA_W-1:0]            out_tdata
);

  localparam int STEPS = eabv_pkg::CORDIC_STEPS;
  localparam int CW    = eabv_pkg::CW;
  localparam int ZW    = eabv_pkg::ZW;
  localparam int SCW   = eabv_pkg::SCW;
  localparam int PW    = eabv_pkg::PW;
  localparam int RW    = eabv_pkg::RW;
  localparam int SW    = eabv_pkg::SW;
  localparam int OUT_W = eabv_pkg::OUT_W;
  localparam int NOUT  = eabv_pkg::NUM_OUT;
  localparam int NST   = eabv_pkg::PIPE_DEPTH;

  // output rounding from Q2.30 down to Q2.FRACTION_BITS
  localparam int SH = eabv_pkg::INNER_BITS - FRACTION_BITS;
  localparam logic signed [SW-1:0] HALF = (SW'(1) << SH) >> 1;
  localparam logic signed [SW-1:0] LIM  = SW'(1) << FRACTION_BITS;

  // lanes
  localparam int L_P = 0;
  localparam int L_Y = 1;
  localparam int L_R = 2;

  // first product round
  localparam int K_SRSP = 0;
  localparam int K_CRSP = 1;
  localparam int K_CPCY = 2;
  localparam int K_CPSY = 3;
  localparam int K_CRSY = 4;
  localparam int K_CRCY = 5;
  localparam int K_SRCP = 6;
  localparam int K_SRSY = 7;
  localparam int K_SRCY = 8;
  localparam int K_CRCP = 9;
  localparam int NK     = 10;

  // second product round (triple products)
  localparam int J_SRSP_CY = 0;
  localparam int J_SRSP_SY = 1;
  localparam int J_CRSP_CY = 2;
  localparam int J_CRSP_SY = 3;
  localparam int NJ        = 4;

  // ---------------------------------------------------------------- handshake
  logic [NST-1:0] vld_r;
  logic           adv;
  logic           in_fire;

  // the whole pipe moves when the output slot is free or being taken
  assign adv        = !vld_r[NST-1] || out_tready;
  assign in_tready  = adv || !vld_r[0];
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_fire};
    end else begin
      vld_r[0] <= vld_r[0] | in_fire;
    end
  end

  // ---------------------------------------------------------------- input register
  logic [ANGLE_BITS-1:0] a_r [0:2];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r[L_P] <= in_tdata[0 +: ANGLE_BITS];
      a_r[L_Y] <= in_tdata[ANGLE_BITS +: ANGLE_BITS];
      a_r[L_R] <= in_tdata[2*ANGLE_BITS +: ANGLE_BITS];
    end
  end

  // ---------------------------------------------------------------- cordic
  // one micro-rotation per stage, three lanes side by side
  logic signed [CW-1:0] cx_r   [1:STEPS][0:2];
  logic signed [CW-1:0] cy_r   [1:STEPS][0:2];
  logic signed [ZW-1:0] cz_r   [1:STEPS][0:2];
  logic        [1:0]    cq_r   [1:STEPS][0:2];
  logic signed [CW-1:0] cx_nxt [1:STEPS][0:2];
  logic signed [CW-1:0] cy_nxt [1:STEPS][0:2];
  logic signed [ZW-1:0] cz_nxt [1:STEPS][0:2];
  logic        [1:0]    cq_nxt [1:STEPS][0:2];

  for (genvar gi = 0; gi < STEPS; gi++) begin : g_cordic
    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [ZW-1:0] zs;
      logic        [1:0]    qs;

      if (gi == 0) begin : g_first
        logic [31:0] turn;
        // angle scaled to a 32-bit turn: top bits pick the quadrant
        assign turn = 32'(a_r[gl]) << (32 - ANGLE_BITS);
        assign xs   = eabv_pkg::CORDIC_GAIN;
        assign ys   = '0;
        assign zs   = ZW'(turn[29:0]);
        assign qs   = turn[31:30];
      end else begin : g_rest
        assign xs = cx_r[gi][gl];
        assign ys = cy_r[gi][gl];
        assign zs = cz_r[gi][gl];
        assign qs = cq_r[gi][gl];
      end

      assign cx_nxt[gi+1][gl] = !zs[ZW-1] ? xs - (ys >>> gi) : xs + (ys >>> gi);
      assign cy_nxt[gi+1][gl] = !zs[ZW-1] ? ys + (xs >>> gi) : ys - (xs >>> gi);
      assign cz_nxt[gi+1][gl] = !zs[ZW-1] ? zs - eabv_pkg::atan_turn(gi)
                                          : zs + eabv_pkg::atan_turn(gi);
      assign cq_nxt[gi+1][gl] = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
      cq_r <= cq_nxt;
    end
  end

  // ---------------------------------------------------------------- quadrant map
  logic signed [SCW-1:0] cs_r   [0:2];
  logic signed [SCW-1:0] sn_r   [0:2];
  logic signed [SCW-1:0] cs_nxt [0:2];
  logic signed [SCW-1:0] sn_nxt [0:2];

  always_comb begin
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    for (int l = 0; l < 3; l++) begin
      x  = cx_r[STEPS][l];
      y  = cy_r[STEPS][l];
      nx = -x;
      ny = -y;
      case (cq_r[STEPS][l])
        2'd0: begin
          cs_nxt[l] = x[SCW-1:0];
          sn_nxt[l] = y[SCW-1:0];
        end
        2'd1: begin
          cs_nxt[l] = ny[SCW-1:0];
          sn_nxt[l] = x[SCW-1:0];
        end
        2'd2: begin
          cs_nxt[l] = nx[SCW-1:0];
          sn_nxt[l] = ny[SCW-1:0];
        end
        default: begin
          cs_nxt[l] = y[SCW-1:0];
          sn_nxt[l] = nx[SCW-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
    end
  end

  // ---------------------------------------------------------------- pairwise products
  logic signed [PW-1:0]  p1_r [0:NK-1];
  logic signed [SCW-1:0] sp1_r, cy1_r, sy1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r[K_SRSP] <= sn_r[L_R] * sn_r[L_P];
      p1_r[K_CRSP] <= cs_r[L_R] * sn_r[L_P];
      p1_r[K_CPCY] <= cs_r[L_P] * cs_r[L_Y];
      p1_r[K_CPSY] <= cs_r[L_P] * sn_r[L_Y];
      p1_r[K_CRSY] <= cs_r[L_R] * sn_r[L_Y];
      p1_r[K_CRCY] <= cs_r[L_R] * cs_r[L_Y];
      p1_r[K_SRCP] <= sn_r[L_R] * cs_r[L_P];
      p1_r[K_SRSY] <= sn_r[L_R] * sn_r[L_Y];
      p1_r[K_SRCY] <= sn_r[L_R] * cs_r[L_Y];
      p1_r[K_CRCP] <= cs_r[L_R] * cs_r[L_P];
      sp1_r        <= sn_r[L_P];
      cy1_r        <= cs_r[L_Y];
      sy1_r        <= sn_r[L_Y];
    end
  end

  // round to Q2.30
  logic signed [RW-1:0]  r2_r [0:NK-1];
  logic signed [SCW-1:0] sp2_r, cy2_r, sy2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NK; k++) begin
        r2_r[k] <= eabv_pkg::qround(p1_r[k]);
      end
      sp2_r <= sp1_r;
      cy2_r <= cy1_r;
      sy2_r <= sy1_r;
    end
  end

  // ---------------------------------------------------------------- triple products
  logic signed [PW-1:0]  m3_r [0:NJ-1];
  logic signed [RW-1:0]  r3_r [0:NK-1];
  logic signed [SCW-1:0] sp3_r;
  logic signed [SCW-1:0] srsp;
  logic signed [SCW-1:0] crsp;

  // both fit Q2.30 in 32 bits
  assign srsp = $signed(r2_r[K_SRSP][SCW-1:0]);
  assign crsp = $signed(r2_r[K_CRSP][SCW-1:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_r[J_SRSP_CY] <= srsp * cy2_r;
      m3_r[J_SRSP_SY] <= srsp * sy2_r;
      m3_r[J_CRSP_CY] <= crsp * cy2_r;
      m3_r[J_CRSP_SY] <= crsp * sy2_r;
      r3_r            <= r2_r;
      sp3_r           <= sp2_r;
    end
  end

  logic signed [RW-1:0]  r4_r  [0:NJ-1];
  logic signed [RW-1:0]  r4p_r [0:NK-1];
  logic signed [SCW-1:0] sp4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NJ; j++) begin
        r4_r[j] <= eabv_pkg::qround(m3_r[j]);
      end
      r4p_r <= r3_r;
      sp4_r <= sp3_r;
    end
  end

  // ---------------------------------------------------------------- vector sums
  logic signed [SW-1:0] sm_r [0:NOUT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r[0] <= SW'(r4p_r[K_CPCY]);
      sm_r[1] <= SW'(r4p_r[K_CPSY]);
      sm_r[2] <= -SW'(sp4_r);
      sm_r[3] <= SW'(r4p_r[K_CRSY]) - SW'(r4_r[J_SRSP_CY]);
      sm_r[4] <= -SW'(r4_r[J_SRSP_SY]) - SW'(r4p_r[K_CRCY]);
      sm_r[5] <= -SW'(r4p_r[K_SRCP]);
      sm_r[6] <= SW'(r4_r[J_CRSP_CY]) + SW'(r4p_r[K_SRSY]);
      sm_r[7] <= SW'(r4_r[J_CRSP_SY]) - SW'(r4p_r[K_SRCY]);
      sm_r[8] <= SW'(r4p_r[K_CRCP]);
    end
  end

  // ---------------------------------------------------------------- output round and clip
  logic [OUT_W-1:0] o_r   [0:NOUT-1];
  logic [OUT_W-1:0] o_nxt [0:NOUT-1];

  always_comb begin
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] r;
    for (int k = 0; k < NOUT; k++) begin
      t = sm_r[k] + HALF;
      r = t >>> SH;
      // gain error can push a component just past unity
      if (r > LIM) begin
        r = LIM;
      end else if (r < -LIM) begin
        r = -LIM;
      end
      o_nxt[k] = r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r <= o_nxt;
    end
  end

  for (genvar gk = 0; gk < NOUT; gk++) begin : g_pack
    assign out_tdata[gk*OUT_W +: OUT_W] = o_r[gk];
  end

endmodule

`default_nettype wire

/* hw/rtl/eabv_checker.sv */
`default_nettype none
`include "euler_angles_to_basis_vectors_core_macros.svh"

module eabv_checker #(
  parameter int ANGLE_BITS = eabv_pkg::ANGLE_BITS_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [((3*ANGLE_BITS+7)/8)*8-1:0]   in_tdata,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [eabv_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int DEPTH = eabv_pkg::PIPE_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  logic             in_fire;
  logic             out_fire;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             in_seen;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_seen  = ^in_tdata || !(^in_tdata);

  // items held inside the block
  assign cnt_nxt = cnt_r + CNT_W'(in_fire) - CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `EABV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output item changed while stalled")
  `EABV_ASSERT_IMPLY(a_in_open, clk, rst_n, (!out_tvalid || out_tready) && in_seen, in_tready, "input blocked while pipe can move")
  `EABV_ASSERT_IMPLY(a_no_phantom, clk, rst_n, out_tvalid, cnt_r != '0, "result shown with no item inside")
  `EABV_ASSERT_IMPLY(a_depth, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH), "more items inside than stages")

endmodule

bind euler_angles_to_basis_vectors_core eabv_checker #(
  .ANGLE_BITS (ANGLE_BITS)
) u_eabv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* tb/sv/euler_angles_to_basis_vectors_core_tb.sv */
`timescale 1ns / 1ps

module euler_angles_to_basis_vectors_core_tb;

  // widths follow the block defaults
  localparam int ANG_W       = eabv_pkg::ANGLE_BITS_DEF;
  localparam int FRAC_W      = eabv_pkg::FRAC_BITS_DEF;
  localparam int IN_W        = ((3 * ANG_W + 7) / 8) * 8;
  localparam int OUT_W       = eabv_pkg::OUT_TDATA_W;
  localparam int LATENCY     = 38;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  // cordic start value, pre-scaled by the inverse gain, q2.30
  localparam longint GAIN_Q30 = 652032874;
  // arctan(2^-i) in 2^-32 turns
  localparam longint ARCTAN_LUT [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  // one input item, pitch in the lowest bits
  typedef struct packed {
    logic [ANG_W-1:0] roll;
    logic [ANG_W-1:0] yaw;
    logic [ANG_W-1:0] pitch;
  } angles_t;

  // one result item, forward_x in the lowest bits
  typedef struct packed {
    logic signed [15:0] up_z;
    logic signed [15:0] up_y;
    logic signed [15:0] up_x;
    logic signed [15:0] right_z;
    logic signed [15:0] right_y;
    logic signed [15:0] right_x;
    logic signed [15:0] forward_z;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_x;
  } basis_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  wire              in_tready;
  // pitch_angle, yaw_angle, roll_angle
  logic [IN_W-1:0]  in_tdata   = '0;
  wire              out_tvalid;
  logic             out_tready = 1'b0;
  // forward_x/y/z, right_x/y/z, up_x/y/z
  wire  [OUT_W-1:0] out_tdata;

  // vectors predicted for accepted items, oldest first
  basis_t pending_vectors [$];
  int     mismatches    = 0;
  int     results_seen  = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;

  // long output hold-off: requested by the stimulus, timed by the ready process
  bit     hold_req   = 1'b0;
  bit     hold_armed = 1'b0;
  int     hold_left  = 0;

  euler_angles_to_basis_vectors_core #(
    .ANGLE_BITS   (ANG_W),
    .FRACTION_BITS(FRAC_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  // sine and cosine of a binary angle in q2.30, quadrant folded after the rotation
  function automatic void cordic_sin_cos(input logic [ANG_W-1:0] ang,
                                         output longint s, output longint c);
    logic [31:0] turn;
    longint      x, y, z, dx, dy;
    turn = 32'(ang) << (32 - ANG_W);
    x = GAIN_Q30;
    y = 0;
    z = longint'(turn[29:0]);
    for (int i = 0; i < 30; i++) begin
      // arithmetic shifts floor, as the hardware does
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_LUT[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_LUT[i];
      end
    end
    case (turn[31:30])
      2'd0: begin
        c = x;
        s = y;
      end
      2'd1: begin
        c = -y;
        s = x;
      end
      2'd2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
  endfunction

  // q2.30 product back to q2.30, half rounded up
  function automatic longint fixed_mul(input longint a, input longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  // q2.30 to the output format, rounded half up, then clipped to +/- one
  function automatic logic signed [15:0] to_fixed_out(input longint v);
    longint lim, r;
    lim = longint'(1) <<< FRAC_W;
    r = (v + (longint'(1) <<< (29 - FRAC_W))) >>> (30 - FRAC_W);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  // forward, right and up vectors for one set of angles
  function automatic basis_t predict_basis(input angles_t a);
    basis_t b;
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    cordic_sin_cos(a.pitch, sp, cp);
    cordic_sin_cos(a.yaw, sy, cy);
    cordic_sin_cos(a.roll, sr, cr);
    srsp = fixed_mul(sr, sp);
    crsp = fixed_mul(cr, sp);
    b.forward_x = to_fixed_out(fixed_mul(cp, cy));
    b.forward_y = to_fixed_out(fixed_mul(cp, sy));
    b.forward_z = to_fixed_out(-sp);
    b.right_x   = to_fixed_out(-fixed_mul(srsp, cy) + fixed_mul(cr, sy));
    b.right_y   = to_fixed_out(-fixed_mul(srsp, sy) - fixed_mul(cr, cy));
    b.right_z   = to_fixed_out(-fixed_mul(sr, cp));
    b.up_x      = to_fixed_out(fixed_mul(crsp, cy) + fixed_mul(sr, sy));
    b.up_y      = to_fixed_out(fixed_mul(crsp, sy) - fixed_mul(sr, cy));
    b.up_z      = to_fixed_out(fixed_mul(cr, cp));
    return b;
  endfunction

  function automatic string field_name(input int k);
    case (k)
      0: return "forward_x";
      1: return "forward_y";
      2: return "forward_z";
      3: return "right_x";
      4: return "right_y";
      5: return "right_z";
      6: return "up_x";
      7: return "up_y";
      default: return "up_z";
    endcase
  endfunction

  // mostly uniform angles, some close to the quadrant boundaries
  function automatic logic [ANG_W-1:0] pick_angle();
    logic [ANG_W-1:0] base;
    if ($urandom_range(0, 4) == 0) begin
      base = ANG_W'($urandom_range(0, 3)) << (ANG_W - 2);
      return base + ANG_W'($urandom_range(0, 6)) - ANG_W'(3);
    end
    return ANG_W'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, $signed(got), $signed(want));
    mismatches++;
  endtask

  // offer one item after a random gap and hold it until it is taken
  task automatic send_angles(input angles_t a);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(a);
    do @(posedge clk); while (!in_tready);
    pending_vectors.push_back(predict_basis(a));
  endtask

  // result side ready: random stalls, or a long hold-off when requested
  always @(posedge clk) begin : drive_ready
    if (hold_req && !hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b1;
    end
    if (!hold_req) hold_armed = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // every accepted result against the oldest prediction, field by field
  always @(posedge clk) begin : check_vectors
    basis_t           want;
    logic [OUT_W-1:0] want_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_vectors.size() == 0) begin
        report_mismatch("result with no item pending", out_tdata[15:0], 16'd0);
      end else begin
        want   = pending_vectors.pop_front();
        want_v = want;
        for (int k = 0; k < 9; k++) begin
          if (out_tdata[16*k +: 16] !== want_v[16*k +: 16])
            report_mismatch(field_name(k), out_tdata[16*k +: 16], want_v[16*k +: 16]);
        end
      end
      results_seen++;
    end
  end

  task automatic test_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // extremes, quadrant edges, one-lsb angles and alternating bit patterns
  task automatic test_corner_angles();
    angles_t corners [$];
    // each entry is {roll, yaw, pitch}
    corners = '{
      {16'h0000, 16'h0000, 16'h0000},   // zero angles, cordic overshoot clipped
      {16'hFFFF, 16'hFFFF, 16'hFFFF},
      {16'h0000, 16'h0000, 16'h4000},
      {16'h0000, 16'h0000, 16'h8000},
      {16'h0000, 16'h0000, 16'hC000},
      {16'h0000, 16'h4000, 16'h0000},
      {16'h0000, 16'h8000, 16'h0000},
      {16'h0000, 16'hC000, 16'h0000},
      {16'h4000, 16'h0000, 16'h0000},
      {16'h8000, 16'h0000, 16'h0000},
      {16'hC000, 16'h0000, 16'h0000},
      {16'h4000, 16'h4000, 16'h4000},
      {16'hC000, 16'h8000, 16'h4000},
      {16'h3FFF, 16'h7FFF, 16'hBFFF},   // just below a quadrant edge
      {16'h4001, 16'h8001, 16'hC001},   // just past a quadrant edge
      {16'h0001, 16'h0001, 16'h0001},
      {16'h2000, 16'h2000, 16'h2000},
      {16'hAAAA, 16'h5555, 16'hAAAA},
      {16'h5555, 16'hAAAA, 16'h5555},
      {16'h1234, 16'hABCD, 16'hF00F}
    };
    foreach (corners[i]) send_angles(corners[i]);
  endtask

  task automatic test_random_stream(input int count, input int send_pct,
                                    input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_angles({pick_angle(), pick_angle(), pick_angle()});
  endtask

  // receiver holds off while items keep coming, so the pipe fills and stalls input
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (100) send_angles({pick_angle(), pick_angle(), pick_angle()});
    hold_req = 1'b0;
  endtask

  initial begin
    test_reset();
    send_idle_pct = 19;
    recv_idle_pct = 61;
    test_corner_angles();
    test_random_stream(500, 19, 61);
    test_random_stream(500, 61, 19);
    test_random_stream(430, 0, 0);
    test_output_hold_off();
    in_tvalid <= 1'b0;
    // drain, then watch a little longer for stray results
    while (pending_vectors.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // cycle counter, ends a hung run
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/eabv_pkg.sv
hw/rtl/euler_angles_to_basis_vectors_core.sv
hw/rtl/eabv_checker.sv
tb/sv/euler_angles_to_basis_vectors_core_tb.sv
